>>> design/mmmv_pkg.sv
// Shared types and constants for the min/max/mean/variance block.
// No dependencies; every other file in the design imports this package.

package mmmv_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_COUNT_DEF = 16;

  // Default divider widths, derived the same way the top level derives them.
  localparam int DEF_LOG_W = $clog2(MAX_COUNT_DEF);
  localparam int DEF_CNT_W = $clog2(MAX_COUNT_DEF + 1);
  localparam int DEF_DVD_W = DEF_CNT_W + 31 + DEF_LOG_W + FRAC_BITS;
  localparam int DEF_DEN_W = 2 * DEF_CNT_W;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic signed [15:0] min_value;
    logic signed [31:0] mean_fixed;
    logic        [45:0] variance_fixed;
    logic        [4:0]  count;
    logic               status;
  } out_t;

endpackage

>>> design/mmmv_accum.sv
// Running statistics: count, max, min, sum and sum of squares of a list.
// Depends on mmmv_pkg.

module mmmv_accum #(
  parameter int MAX_COUNT = mmmv_pkg::MAX_COUNT_DEF,
  localparam int CNT_W = $clog2(MAX_COUNT + 1),
  localparam int SUM_W = 16 + $clog2(MAX_COUNT),
  localparam int SQ_W  = 31 + $clog2(MAX_COUNT)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic                     en,
  input  logic signed [15:0]       sample,
  output logic        [CNT_W-1:0]  count,
  output logic signed [15:0]       max_value,
  output logic signed [15:0]       min_value,
  output logic signed [SUM_W-1:0]  sum,
  output logic        [SQ_W-1:0]   square_sum,
  output logic                     overflow
);
  import mmmv_pkg::*;

  logic signed [31:0] square;
  logic               has_room;

  assign square   = 32'(sample) * 32'(sample);
  assign has_room = count < CNT_W'(MAX_COUNT);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count      <= '0;
      max_value  <= '0;
      min_value  <= '0;
      sum        <= '0;
      square_sum <= '0;
      overflow   <= 1'b0;
    end else if (en) begin
      if (has_room) begin
        // The first sample of a list seeds both extremes.
        if (count == '0 || sample > max_value) begin
          max_value <= sample;
        end
        if (count == '0 || sample < min_value) begin
          min_value <= sample;
        end
        sum        <= sum + SUM_W'(sample);
        square_sum <= square_sum + SQ_W'($unsigned(square));
        count      <= count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

>>> design/mmmv_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on mmmv_pkg for its default widths.

module mmmv_div #(
  parameter int DVD_W = mmmv_pkg::DEF_DVD_W,
  parameter int DEN_W = mmmv_pkg::DEF_DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DEN_W-1:0] remainder
);
  import mmmv_pkg::*;

  localparam int STEP_W = $clog2(DVD_W);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    shifted;
  logic [DEN_W:0]    diff;

  // The quotient register shifts dividend bits out at the top while
  // quotient bits enter at the bottom.
  assign shifted = {remainder, quotient[DVD_W-1]};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == STEP_W'(DVD_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      den       <= divisor;
      step      <= '0;
    end else if (running) begin
      step <= step + 1'b1;
      if (!diff[DEN_W]) begin
        remainder <= diff[DEN_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b1};
      end else begin
        remainder <= shifted[DEN_W-1:0];
        quotient  <= {quotient[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> design/min_max_mean_variance_top.sv
// Top level of the min/max/mean/variance block: sequencer, end-of-list math.
// Depends on mmmv_pkg, mmmv_accum and mmmv_div.
//
//   channel | ports                  | beat taken when
//   --------+------------------------+---------------------------
//   input   | start, busy, item      | start high and busy low
//   result  | done, result           | done high (one cycle, no stall)
//
// Each sample is captured in S_IDLE and added to the running statistics
// in S_ACC. After the last sample of a list, the mean and the variance
// go one after the other through the bit-serial divider, whose width
// is DW = CNT_W + SQ_W + 16 bits (56 at MAX_COUNT = 16).
// Reset is synchronous and clears all running state; the result strobe is
// a single cycle and the receiver has no way to hold it off.

module min_max_mean_variance_top #(
  parameter int MAX_COUNT = mmmv_pkg::MAX_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mmmv_pkg::in_t item,
  output logic          done,
  output mmmv_pkg::out_t result
);
  import mmmv_pkg::*;

  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = 16 + $clog2(MAX_COUNT);
  localparam int SQ_W  = 31 + $clog2(MAX_COUNT);
  localparam int NUM_W = CNT_W + SQ_W;
  localparam int DVD_W = NUM_W + FRAC_BITS;
  localparam int DEN_W = 2 * CNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_DIVM = 3'd4;
  localparam logic [2:0] S_DIVV = 3'd5;

  logic [2:0] state;
  in_t        held;

  logic        [CNT_W-1:0]   acc_count;
  logic signed [15:0]        acc_max;
  logic signed [15:0]        acc_min;
  logic signed [SUM_W-1:0]   acc_sum;
  logic        [SQ_W-1:0]    acc_sq;
  logic                      acc_ovf;
  logic                      acc_clear;

  logic        [NUM_W-1:0]   n_sumsq;
  logic signed [2*SUM_W-1:0] sum_sq;
  logic        [DEN_W-1:0]   n_sq;
  logic        [NUM_W-1:0]   num;
  logic        [SUM_W-1:0]   sum_mag;
  logic signed [31:0]        mean;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_done;
  logic [DVD_W-1:0] div_quot;
  logic [DEN_W-1:0] div_rem;
  logic [DVD_W-1:0] quot_up;
  logic [DVD_W-1:0] mean_full;

  assign busy = state != S_IDLE;

  mmmv_accum #(
    .MAX_COUNT(MAX_COUNT)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .clear     (acc_clear),
    .en        (state == S_ACC),
    .sample    (held.sample),
    .count     (acc_count),
    .max_value (acc_max),
    .min_value (acc_min),
    .sum       (acc_sum),
    .square_sum(acc_sq),
    .overflow  (acc_ovf)
  );

  mmmv_div #(
    .DVD_W(DVD_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  assign sum_mag = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);

  // Floor division of a negative sum rounds the magnitude quotient up.
  assign quot_up   = div_quot + DVD_W'(div_rem != '0);
  assign mean_full = acc_sum[SUM_W-1] ? -quot_up : div_quot;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DVD_W'(sum_mag) << FRAC_BITS;
    div_divisor  = DEN_W'(acc_count);
    acc_clear    = 1'b0;
    case (state)
      S_SUB: begin
        div_start = 1'b1;
      end
      S_DIVM: begin
        div_start    = div_done;
        div_dividend = DVD_W'(num) << FRAC_BITS;
        div_divisor  = n_sq;
      end
      S_DIVV: begin
        acc_clear = div_done;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= held.last ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          state <= S_SUB;
        end
        S_SUB: begin
          state <= S_DIVM;
        end
        S_DIVM: begin
          if (div_done) begin
            state <= S_DIVV;
          end
        end
        S_DIVV: begin
          if (div_done) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      held <= item;
    end
    if (state == S_MUL) begin
      n_sumsq <= NUM_W'(acc_count) * NUM_W'(acc_sq);
      sum_sq  <= (2*SUM_W)'(acc_sum) * (2*SUM_W)'(acc_sum);
      n_sq    <= DEN_W'(acc_count) * DEN_W'(acc_count);
    end
    if (state == S_SUB) begin
      num <= n_sumsq - NUM_W'($unsigned(sum_sq));
    end
    if (state == S_DIVM && div_done) begin
      mean <= mean_full[31:0];
    end
    if (state == S_DIVV && div_done) begin
      result.max_value      <= acc_max;
      result.min_value      <= acc_min;
      result.mean_fixed     <= mean;
      result.variance_fixed <= div_quot[45:0];
      result.count          <= 5'(acc_count);
      result.status         <= acc_ovf;
    end
  end

endmodule
